[src/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 24;
    localparam int HANDLE_BITS = 9;
    localparam int RANK_BITS   = 6;
    localparam int FILL_BITS   = 7;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    typedef struct packed {
        t_status                status;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [FILL_BITS-1:0]   fill;
    } t_result;

    // Physical slot of a rank in the circular store that starts at head.
    function automatic logic [AW-1:0] spq_phys(logic [AW-1:0] head, logic [CW-1:0] lpos);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(lpos);
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

[src/spq_if.sv]
interface spq_cmd_if;
    import spq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [RANK_BITS-1:0]   rank;

    modport source (output valid, action, key, handle, rank, input ready);
    modport sink   (input valid, action, key, handle, rank, output ready);
endinterface

interface spq_res_if;
    import spq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [KEY_BITS-1:0]    out_key;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [FILL_BITS-1:0]   fill;

    modport source (output valid, status, out_key, out_handle, fill, input ready);
    modport sink   (input valid, status, out_key, out_handle, fill, output ready);
endinterface

[src/spq_ram.sv]
module spq_ram
    import spq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sorted_priority_queue.sv]
// Path from an accepted command beat to its result beat: clear, full insert, empty pop
// and an out-of-range read go straight to S_DONE; pop and read pass S_RD first.
// Insert shifts stored entries toward the tail in S_INS_CMP, one per step, then writes its
// own entry, the walk bounded by one read and one write of the entry memory per cycle.
// A new command beat is accepted the cycle after the result enters the output register.
// Synchronous active-low reset empties the queue; the entry memory is not cleared.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_cmd_if.sink   i_cmd,
    spq_res_if.source o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_INS_CMP,
        S_INS_WR,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_pos, n_pos;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    t_result                r_res, n_res;
    t_result                r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [CW-1:0] rd_lpos;
    t_entry        mem_rdata;
    t_action       act;

    assign act = t_action'(i_cmd.action);

    spq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (spq_phys(r_head, rd_lpos)),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_handle    = r_handle;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = spq_phys(r_head, r_pos);
        mem_wdata   = mem_rdata;
        rd_lpos     = r_pos - CW'(2);

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                unique case (act)
                    ACT_READ:   rd_lpos = CW'(i_cmd.rank);
                    ACT_INSERT: rd_lpos = r_count - CW'(1);
                    ACT_POP:    rd_lpos = '0;
                    ACT_CLEAR:  rd_lpos = '0;
                endcase
                if (i_cmd.valid) begin
                    n_res   = '{status: ST_OK, key: '0, handle: '0, fill: FILL_BITS'(r_count)};
                    n_state = S_DONE;
                    n_key   = i_cmd.key;
                    n_handle = i_cmd.handle;
                    unique case (act)
                        ACT_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_pos   = r_count;
                                n_state = (r_count == '0) ? S_INS_WR : S_INS_CMP;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_head  = spq_phys(r_head, CW'(1));
                                n_state = S_RD;
                            end
                        end
                        ACT_READ: begin
                            if (CW'(i_cmd.rank) >= r_count) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count    = '0;
                            n_res.fill = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_res   = '{status: ST_OK, key: mem_rdata.key, handle: mem_rdata.handle,
                            fill: FILL_BITS'(r_count)};
                n_state = S_DONE;
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (r_key > mem_rdata.key) begin
                    mem_wdata = '{key: r_key, handle: r_handle};
                    n_res     = '{status: ST_OK, key: '0, handle: '0,
                                  fill: FILL_BITS'(r_count)};
                    n_state   = S_DONE;
                end else begin
                    n_pos = r_pos - CW'(1);
                    if (r_pos == CW'(1)) begin
                        n_state = S_INS_WR;
                    end
                end
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_wdata = '{key: r_key, handle: r_handle};
                n_res     = '{status: ST_OK, key: '0, handle: '0, fill: FILL_BITS'(r_count)};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_handle <= n_handle;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.out_key    = r_out.key;
    assign o_res.out_handle = r_out.handle;
    assign o_res.fill       = r_out.fill;

endmodule

[src/spq_checker.sv]
module spq_checker
    import spq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [1:0]             i_status,
    input logic [KEY_BITS-1:0]    i_out_key,
    input logic [HANDLE_BITS-1:0] i_out_handle,
    input logic [FILL_BITS-1:0]   i_fill
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_key) && $stable(i_out_handle) && $stable(i_fill))
        else $error("Result beat changed while stalled.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_out_key == '0 && i_out_handle == '0)
        else $error("Failed command returned entry data.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_fill <= FILL_BITS'(DEPTH) && i_status != 2'd3)
        else $error("Fill or status out of range.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Command taken while the previous one is still in work.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_out_key    (o_res.out_key),
    .i_out_handle (o_res.out_handle),
    .i_fill       (o_res.fill)
);

[tb/sv/tb_sorted_priority_queue.sv]
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int KEY_MAX        = (1 << KEY_BITS) - 1;
    localparam int HANDLE_MAX     = (1 << HANDLE_BITS) - 1;
    localparam int RANK_MAX       = (1 << RANK_BITS) - 1;
    localparam int STALL_MAX      = 11;
    localparam int HOLD_CYCLES    = 160;
    localparam int SETTLE_CYCLES  = DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spq_cmd_if cmd_bus ();
    spq_res_if res_bus ();

    sorted_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    logic [KEY_BITS-1:0]    model_keys    [DEPTH];
    logic [HANDLE_BITS-1:0] model_handles [DEPTH];
    int                     model_fill;
    t_result                due_results [$];

    bit tx_idle_on;
    bit rx_idle_on;
    int hold_len;
    int quiet_cycles;
    int error_count;
    int beats_sent;
    int beats_checked;
    int peak_fill;
    int full_drops;
    int empty_replies;
    int clears_done;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result apply_queue_op(t_action act, logic [KEY_BITS-1:0] key,
                                               logic [HANDLE_BITS-1:0] handle,
                                               logic [RANK_BITS-1:0] rank);
        t_result r;
        int      pos;
        int      i;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < model_fill && key > model_keys[pos]) pos++;
                    for (i = model_fill; i > pos; i--) begin
                        model_keys[i]    = model_keys[i-1];
                        model_handles[i] = model_handles[i-1];
                    end
                    model_keys[pos]    = key;
                    model_handles[pos] = handle;
                    model_fill++;
                    if (model_fill > peak_fill) peak_fill = model_fill;
                end
            end
            ACT_POP: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_replies++;
                end else begin
                    r.key    = model_keys[0];
                    r.handle = model_handles[0];
                    for (i = 1; i < model_fill; i++) begin
                        model_keys[i-1]    = model_keys[i];
                        model_handles[i-1] = model_handles[i];
                    end
                    model_fill--;
                end
            end
            ACT_READ: begin
                if (int'(rank) >= model_fill) begin
                    r.status = ST_EMPTY;
                    empty_replies++;
                end else begin
                    r.key    = model_keys[rank];
                    r.handle = model_handles[rank];
                end
            end
            default: begin
                model_fill = 0;
                clears_done++;
            end
        endcase
        r.fill = FILL_BITS'(model_fill);
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key(bit narrow);
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return '0;
        if (roll == 1) return KEY_BITS'(KEY_MAX);
        if (narrow) return KEY_BITS'($urandom_range(0, 3));
        return KEY_BITS'($urandom);
    endfunction

    function automatic logic [RANK_BITS-1:0] rand_rank();
        if (model_fill > 0 && $urandom_range(0, 2) != 0)
            return RANK_BITS'($urandom_range(0, model_fill - 1));
        return RANK_BITS'($urandom_range(0, RANK_MAX));
    endfunction

    function automatic t_action pick_action(int w_ins, int w_pop, int w_read, int w_clr);
        int roll;
        roll = $urandom_range(0, w_ins + w_pop + w_read + w_clr - 1);
        if (roll < w_ins) return ACT_INSERT;
        if (roll < w_ins + w_pop) return ACT_POP;
        if (roll < w_ins + w_pop + w_read) return ACT_READ;
        return ACT_CLEAR;
    endfunction

    task automatic send_cmd(t_action act, logic [KEY_BITS-1:0] key,
                            logic [HANDLE_BITS-1:0] handle, logic [RANK_BITS-1:0] rank);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= act;
        cmd_bus.key    <= key;
        cmd_bus.handle <= handle;
        cmd_bus.rank   <= rank;
        do @(posedge i_clk); while (!cmd_bus.ready);
        due_results.push_back(apply_queue_op(act, key, handle, rank));
        beats_sent++;
    endtask

    task automatic send_random(t_action act, bit narrow);
        send_cmd(act, rand_key(narrow), HANDLE_BITS'($urandom_range(0, HANDLE_MAX)),
                 rand_rank());
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result beat with none due, expected nothing, actual %0h %0h %0h %0d",
                         $time, res_bus.status, res_bus.out_key, res_bus.out_handle,
                         res_bus.fill);
                error_count++;
            end else begin
                want = due_results.pop_front();
                beats_checked++;
                check_field("status", 32'(want.status), 32'(res_bus.status));
                check_field("out_key", 32'(want.key), 32'(res_bus.out_key));
                check_field("out_handle", 32'(want.handle), 32'(res_bus.out_handle));
                check_field("fill", 32'(want.fill), 32'(res_bus.fill));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        int stall;
        res_bus.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_len > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid && hold_len == 0);
        end
    end

    task automatic test_directed();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_cmd(ACT_POP, '0, '0, '0);
        send_cmd(ACT_READ, '0, '0, '0);
        send_cmd(ACT_READ, '0, '0, RANK_BITS'(RANK_MAX));
        send_cmd(ACT_INSERT, KEY_BITS'(KEY_MAX), HANDLE_BITS'(HANDLE_MAX), '0);
        send_cmd(ACT_INSERT, '0, '0, '0);
        send_cmd(ACT_INSERT, 24'd5, 9'd1, '0);
        send_cmd(ACT_INSERT, 24'd5, 9'd2, '0);
        send_cmd(ACT_INSERT, 24'd5, 9'd3, '0);
        send_cmd(ACT_READ, '0, '0, 6'd0);
        send_cmd(ACT_READ, '0, '0, 6'd1);
        send_cmd(ACT_READ, '0, '0, 6'd2);
        send_cmd(ACT_READ, '0, '0, 6'd3);
        send_cmd(ACT_READ, '0, '0, 6'd4);
        send_cmd(ACT_READ, '0, '0, 6'd5);
        send_cmd(ACT_READ, '0, '0, RANK_BITS'(RANK_MAX));
        send_cmd(ACT_POP, '0, '0, '0);
        send_cmd(ACT_POP, '0, '0, '0);
        send_cmd(ACT_INSERT, 24'd5, 9'd4, '0);
        send_cmd(ACT_READ, '0, '0, 6'd0);
        send_cmd(ACT_CLEAR, KEY_BITS'(KEY_MAX), HANDLE_BITS'(HANDLE_MAX), '0);
        send_cmd(ACT_POP, '0, '0, '0);
        send_cmd(ACT_CLEAR, '0, '0, '0);
        drain_results();
    endtask

    task automatic test_mixed(int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count) send_random(pick_action(45, 22, 30, 3), 1'b0);
    endtask

    task automatic test_fill_to_full();
        int i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_len = HOLD_CYCLES;
        while (model_fill < DEPTH) send_random(ACT_INSERT, 1'($urandom_range(0, 1)));
        for (i = 0; i < 3; i++) send_random(ACT_INSERT, 1'b0);
        send_cmd(ACT_READ, '0, '0, '0);
        send_cmd(ACT_READ, '0, '0, RANK_BITS'(DEPTH - 1));
        send_random(ACT_READ, 1'b0);
    endtask

    task automatic test_drain_to_empty();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        while (model_fill > 0) send_random(pick_action(0, 8, 2, 0), 1'b0);
        send_random(ACT_POP, 1'b0);
        send_random(ACT_READ, 1'b0);
    endtask

    task automatic test_pauses(int count);
        int i;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (i = 0; i < count; i++) begin
            send_random(pick_action(50, 20, 28, 2), 1'b0);
            if (i % 10 == 9) drain_results();
        end
    endtask

    task automatic test_equal_keys(int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count) send_random(pick_action(50, 25, 23, 2), 1'b1);
    endtask

    initial begin
        cmd_bus.valid  <= 1'b0;
        cmd_bus.action <= ACT_INSERT;
        cmd_bus.key    <= '0;
        cmd_bus.handle <= '0;
        cmd_bus.rank   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_mixed(120);
        test_fill_to_full();
        test_drain_to_empty();
        test_pauses(40);
        test_equal_keys(100);
        test_mixed(40);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d results still due at the end, expected 0, actual %0d",
                     $time, due_results.size(), due_results.size());
            error_count++;
        end
        $display("Sent %0d command beats, checked %0d result beats, peak fill %0d of %0d.",
                 beats_sent, beats_checked, peak_fill, DEPTH);
        $display("Saw %0d dropped inserts, %0d empty or out-of-range replies, %0d clears.",
                 full_drops, empty_replies, clears_done);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sorted_priority_queue.f]
src/spq_pkg.sv
src/spq_if.sv
src/spq_ram.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
tb/sv/tb_sorted_priority_queue.sv
